[rtl/core/ptb_pkg.sv]
// Shared types and constants of the point-in-triangle block.
`default_nettype none

package ptb_pkg;

  localparam int FIELD_W   = 16;  // width of one point coordinate field
  localparam int VERTEX_W  = 48;  // width of one vertex register
  localparam int UNPACK_W  = 64;  // room for three coordinates at the widest setting
  localparam int WEIGHT_W  = 24;  // Q7.16 weight
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;

  localparam logic [WEIGHT_W-1:0] POS_LIMIT = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] NEG_LIMIT = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_z;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_x;
  } ptb_in_t;

  typedef struct packed {
    logic                       inside_res;
    logic                       degenerate;
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
  } ptb_out_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
  } ptb_div_ctl_t;

endpackage

`default_nettype wire

[rtl/core/ptb_div.sv]
// Pipelined restoring divider: saturating Q7.16 weight from a magnitude and a denominator.
`default_nettype none

module ptb_div #(
  parameter int MAG_W = 74,
  parameter int DEN_W = 72
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptb_pkg::ptb_div_ctl_t         ctl_i,
  input  logic [MAG_W-1:0]              mag_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic                          valid_o,
  output logic [ptb_pkg::WEIGHT_W-1:0]  weight_o
);
  import ptb_pkg::*;

  localparam int QB = WEIGHT_W;
  localparam int RW = (MAG_W + FRAC_BITS > DEN_W + QB) ? MAG_W + FRAC_BITS : DEN_W + QB;

  ptb_div_ctl_t      ctl_q [QB];
  logic [RW-1:0]     rem_q [QB];
  logic [QB-1:0]     quo_q [QB];
  logic [DEN_W-1:0]  den_q [QB-1];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0]    r_in;
    logic [RW-1:0]    sh;
    logic [QB-1:0]    q_in;
    logic [DEN_W-1:0] d_in;
    ptb_div_ctl_t     c_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = RW'({mag_i, {FRAC_BITS{1'b0}}});
      assign q_in = '0;
      assign d_in = den_i;
      assign c_in = ctl_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = den_q[k-1];
      assign c_in = ctl_q[k-1];
    end

    assign sh = RW'(d_in) << BIT;
    assign ge = (r_in >= sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (r_in - sh) : r_in;
      quo_q[k] <= q_in | (QB'(ge) << BIT);
    end

    if (k < QB - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        den_q[k] <= d_in;
      end
    end
  end

  logic [QB-1:0]       q_fin;
  ptb_div_ctl_t        c_fin;
  logic [WEIGHT_W-1:0] weight_d;
  logic [WEIGHT_W-1:0] weight_q;
  logic                valid_q;

  assign q_fin = quo_q[QB-1];
  assign c_fin = ctl_q[QB-1];

  // clamp to the Q7.16 range, negative side reaches one step further
  always_comb begin
    if (c_fin.neg) begin
      weight_d = (c_fin.sat || q_fin > NEG_LIMIT) ? NEG_LIMIT : (~q_fin + 1'b1);
    end else begin
      weight_d = (c_fin.sat || q_fin > POS_LIMIT) ? POS_LIMIT : q_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= c_fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
  end

  assign valid_o  = valid_q;
  assign weight_o = weight_q;

endmodule

`default_nettype wire

[rtl/core/point_in_triangle_barycentric_top.sv]
// Top level of the barycentric point-in-triangle test.
//
//   port group      dir  handshake                   word
//   pt_i            in   start_i & !busy_o           query point x, y, z
//   res_o           out  res_valid_o (1-cycle pulse) inside, degenerate, three weights
//   cfg_*           in   cfg_valid_i & cfg_ready_o   vertex register write
//
// One point enters per cycle; each result passes through six arithmetic stages (differences,
// cross product terms, cross products, dot product terms, sums, numerator/magnitude) and a
// 24-stage divider, one quotient bit per stage, plus the divider and result output registers.
// Reset clears the vertex registers to zero and all valid bits; data registers are not reset.
// The receiver cannot stall, so busy_o stays low and cfg_ready_o stays high.
`default_nettype none

module point_in_triangle_barycentric_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  ptb_pkg::ptb_in_t                   pt_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptb_pkg::VERTEX_W-1:0]       cfg_data_i,
  output logic                               res_valid_o,
  output ptb_pkg::ptb_out_t                  res_o
);
  import ptb_pkg::*;

  localparam int EW = COORD_BITS + 1;  // edge and offset
  localparam int PW = 2 * EW;          // cross product term
  localparam int VW = PW + 1;          // cross product
  localparam int QW = 2 * VW;          // dot product term
  localparam int DW = QW + 2;          // den, num_b, num_c
  localparam int NW = DW + 2;          // num_a and magnitudes
  localparam int PIPE_LAT = 6 + WEIGHT_W + 2;

  // ---------------------------------------------------------------- config
  logic [VERTEX_W-1:0] vtx_a_q, vtx_b_q, vtx_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q <= '0;
      vtx_b_q <= '0;
      vtx_c_q <= '0;
    end else if (cfg_valid_i) begin
      // an index beyond the list writes nothing
      case (cfg_index_i)
        REG_VERTEX_A: vtx_a_q <= cfg_data_i;
        REG_VERTEX_B: vtx_b_q <= cfg_data_i;
        REG_VERTEX_C: vtx_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------- unpack
  logic [UNPACK_W-1:0] a_ext, b_ext, c_ext;
  logic [UNPACK_W-1:0] p_ext [3];
  logic signed [COORD_BITS-1:0] ca [3], cb [3], cc [3], cp [3];

  assign a_ext    = UNPACK_W'(vtx_a_q);
  assign b_ext    = UNPACK_W'(vtx_b_q);
  assign c_ext    = UNPACK_W'(vtx_c_q);
  assign p_ext[0] = UNPACK_W'($unsigned(pt_i.point_x));
  assign p_ext[1] = UNPACK_W'($unsigned(pt_i.point_y));
  assign p_ext[2] = UNPACK_W'($unsigned(pt_i.point_z));

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign ca[k] = $signed(a_ext[k*COORD_BITS +: COORD_BITS]);
    assign cb[k] = $signed(b_ext[k*COORD_BITS +: COORD_BITS]);
    assign cc[k] = $signed(c_ext[k*COORD_BITS +: COORD_BITS]);
    assign cp[k] = $signed(p_ext[k][COORD_BITS-1:0]);
  end

  // ---------------------------------------------------------------- valid chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------- stages 1 to 5
  logic signed [EW-1:0] e1_q [3], e2_q [3], d_q [3];
  logic signed [PW-1:0] pn_q [3][2], pb_q [3][2], pc_q [3][2];
  logic signed [VW-1:0] n_q [3], xb_q [3], xc_q [3];
  logic signed [QW-1:0] dn_q [3], db_q [3], dc_q [3];
  logic signed [DW-1:0] den_q, nb_q, nc_q;

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int J1 = (k + 1) % 3;
    localparam int J2 = (k + 2) % 3;

    always_ff @(posedge clk_i) begin
      // stage 1: edges and point offset
      e1_q[k] <= EW'(cb[k]) - EW'(ca[k]);
      e2_q[k] <= EW'(cc[k]) - EW'(ca[k]);
      d_q[k]  <= EW'(cp[k]) - EW'(ca[k]);
      // stage 2: cross product terms for n = e1 x e2, xb = d x e2, xc = e1 x d
      pn_q[k][0] <= e1_q[J1] * e2_q[J2];
      pn_q[k][1] <= e1_q[J2] * e2_q[J1];
      pb_q[k][0] <= d_q[J1] * e2_q[J2];
      pb_q[k][1] <= d_q[J2] * e2_q[J1];
      pc_q[k][0] <= e1_q[J1] * d_q[J2];
      pc_q[k][1] <= e1_q[J2] * d_q[J1];
      // stage 3: cross products
      n_q[k]  <= VW'(pn_q[k][0]) - VW'(pn_q[k][1]);
      xb_q[k] <= VW'(pb_q[k][0]) - VW'(pb_q[k][1]);
      xc_q[k] <= VW'(pc_q[k][0]) - VW'(pc_q[k][1]);
      // stage 4: dot product terms against the normal
      dn_q[k] <= n_q[k] * n_q[k];
      db_q[k] <= n_q[k] * xb_q[k];
      dc_q[k] <= n_q[k] * xc_q[k];
    end
  end

  // stage 5: dot product sums
  always_ff @(posedge clk_i) begin
    den_q <= DW'(dn_q[0]) + DW'(dn_q[1]) + DW'(dn_q[2]);
    nb_q  <= DW'(db_q[0]) + DW'(db_q[1]) + DW'(db_q[2]);
    nc_q  <= DW'(dc_q[0]) + DW'(dc_q[1]) + DW'(dc_q[2]);
  end

  // ---------------------------------------------------------------- stage 6
  logic signed [NW-1:0] na, nbx, ncx;
  logic [NW-1:0]        ma, mb, mc;
  logic [NW+7:0]        den_sh;

  assign na  = NW'(den_q) - NW'(nb_q) - NW'(nc_q);
  assign nbx = NW'(nb_q);
  assign ncx = NW'(nc_q);
  assign ma  = na[NW-1]  ? NW'(-na)  : NW'(na);
  assign mb  = nbx[NW-1] ? NW'(-nbx) : NW'(nbx);
  assign mc  = ncx[NW-1] ? NW'(-ncx) : NW'(ncx);
  // quotient reaches 2^24 or more when mag >= den * 2^8
  assign den_sh = (NW+8)'($unsigned(den_q)) << 8;

  ptb_div_ctl_t     ctl_a_q, ctl_b_q, ctl_c_q;
  logic [NW-1:0]    mag_a_q, mag_b_q, mag_c_q;
  logic [DW-1:0]    den6_q;
  logic             inside6_q, degen6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else begin
      ctl_a_q <= '{valid: v5_q, neg: na[NW-1],  sat: ((NW+8)'(ma) >= den_sh)};
      ctl_b_q <= '{valid: v5_q, neg: nbx[NW-1], sat: ((NW+8)'(mb) >= den_sh)};
      ctl_c_q <= '{valid: v5_q, neg: ncx[NW-1], sat: ((NW+8)'(mc) >= den_sh)};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q   <= ma;
    mag_b_q   <= mb;
    mag_c_q   <= mc;
    den6_q    <= $unsigned(den_q);
    inside6_q <= !na[NW-1] && !nbx[NW-1] && !ncx[NW-1];
    degen6_q  <= (den_q == '0);
  end

  // ---------------------------------------------------------------- dividers
  logic                va_v, vb_v, vc_v;
  logic [WEIGHT_W-1:0] wa, wb, wc;

  ptb_div #(.MAG_W(NW), .DEN_W(DW)) u_div_a (
    .clk_i, .rst_ni, .ctl_i(ctl_a_q), .mag_i(mag_a_q), .den_i(den6_q),
    .valid_o(va_v), .weight_o(wa)
  );

  ptb_div #(.MAG_W(NW), .DEN_W(DW)) u_div_b (
    .clk_i, .rst_ni, .ctl_i(ctl_b_q), .mag_i(mag_b_q), .den_i(den6_q),
    .valid_o(vb_v), .weight_o(wb)
  );

  ptb_div #(.MAG_W(NW), .DEN_W(DW)) u_div_c (
    .clk_i, .rst_ni, .ctl_i(ctl_c_q), .mag_i(mag_c_q), .den_i(den6_q),
    .valid_o(vc_v), .weight_o(wc)
  );

  // carry inside and degenerate alongside the dividers
  logic [1:0] side_q [WEIGHT_W+1];

  always_ff @(posedge clk_i) begin
    side_q[0] <= {inside6_q, degen6_q};
  end

  for (genvar s = 1; s <= WEIGHT_W; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // ---------------------------------------------------------------- result
  logic     res_valid_q;
  ptb_out_t res_q;
  logic     degen_fin;

  assign degen_fin = side_q[WEIGHT_W][0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= va_v;
    end
  end

  // zero-area triangle: drop the inside flag and the weights
  always_ff @(posedge clk_i) begin
    res_q.inside_res <= side_q[WEIGHT_W][1] && !degen_fin;
    res_q.degenerate <= degen_fin;
    res_q.weight_a   <= degen_fin ? '0 : $signed(wa);
    res_q.weight_b   <= degen_fin ? '0 : $signed(wb);
    res_q.weight_c   <= degen_fin ? '0 : $signed(wc);
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------------------------------------------------------- checks
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_v == vb_v && va_v == vc_v)
    else $error("divider lanes out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LAT res_valid_o)
    else $error("result missing after accepted word");

  a_degen_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.degenerate |->
      !res_o.inside_res && res_o.weight_a == '0 && res_o.weight_b == '0
      && res_o.weight_c == '0)
    else $error("degenerate result carries data");

  a_inside_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.inside_res |->
      !res_o.weight_a[WEIGHT_W-1] && !res_o.weight_b[WEIGHT_W-1]
      && !res_o.weight_c[WEIGHT_W-1])
    else $error("inside point with negative weight");

endmodule

`default_nettype wire
